[hw/rtl/bitmap_page_allocator_macros.svh]
// Assertion macros used by the allocator engine RTL.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define BPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define BPA_ASSERT(label, clk, rst_n, prop, msg)
`define BPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/bpa_pkg.sv]
package bpa_pkg;

    localparam int NUM_PAGES_DEF  = 32768;
    localparam int PAGE_SHIFT_DEF = 12;

    // page numbers and inclusive range bounds, wide enough for 2^20 pages
    localparam int PAGE_W   = 21;
    localparam int ADDR_W   = 64;
    localparam int USABLE_W = 16;
    localparam int FIRST_W  = 15;
    localparam int COUNT_W  = 16;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MARK  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECT_MAP_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USABLE_PAGES      = 1'd1;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_MARK,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [PAGE_W-1:0]     lo;
        logic [PAGE_W-1:0]     hi;
        logic [STATUS_W-1:0]   status;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_RMW_RD,
        ST_RMW_WR
    } eng_state_t;

endpackage

[hw/rtl/bpa_front.sv]
module bpa_front #(
    parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [95:0]                   s_tdata,
    input  logic [bpa_pkg::ACTION_W-1:0]  s_tuser,
    input  logic [bpa_pkg::ADDR_W-1:0]    direct_map_offset,
    input  logic                          clearing,
    input  logic                          fifo_full,
    output logic                          push,
    output bpa_pkg::cmd_t                 cmd
);

    localparam logic [bpa_pkg::PAGE_W-1:0] NUM_P = bpa_pkg::PAGE_W'(NUM_PAGES);

    logic [bpa_pkg::ADDR_W-1:0]  diff;
    logic [bpa_pkg::ADDR_W-1:0]  free_page;
    logic [bpa_pkg::PAGE_W-1:0]  first;
    logic [bpa_pkg::PAGE_W-1:0]  count;
    logic [bpa_pkg::PAGE_W-1:0]  range_end;

    // take words only once the map is cleared and the queue has room
    assign s_tready = !clearing && !fifo_full;
    assign push     = s_tvalid && s_tready;

    // turn the direct-mapped address back into a page number
    assign diff      = s_tdata[63:0] - direct_map_offset;
    assign free_page = diff >> PAGE_SHIFT;
    assign first     = bpa_pkg::PAGE_W'(s_tdata[78:64]);
    assign count     = bpa_pkg::PAGE_W'(s_tdata[94:79]);
    assign range_end = first + count;

    // classify the word into a command for the back end
    always_comb
    begin
        cmd.kind   = bpa_pkg::CMD_NOP;
        cmd.lo     = '0;
        cmd.hi     = '0;
        cmd.status = bpa_pkg::STATUS_OK;
        unique case (s_tuser)
            bpa_pkg::ACT_ALLOC:
            begin
                cmd.kind = bpa_pkg::CMD_ALLOC;
            end
            bpa_pkg::ACT_FREE:
            begin
                if (free_page >= bpa_pkg::ADDR_W'(NUM_PAGES))
                begin
                    cmd.status = bpa_pkg::STATUS_RANGE;
                end
                else
                begin
                    cmd.kind = bpa_pkg::CMD_FREE;
                    cmd.lo   = bpa_pkg::PAGE_W'(free_page);
                    cmd.hi   = bpa_pkg::PAGE_W'(free_page);
                end
            end
            bpa_pkg::ACT_MARK:
            begin
                if (count != '0)
                begin
                    if (range_end > NUM_P)
                    begin
                        cmd.status = bpa_pkg::STATUS_RANGE;
                    end
                    if (first < NUM_P)
                    begin
                        cmd.kind = bpa_pkg::CMD_MARK;
                        cmd.lo   = first;
                        cmd.hi   = (range_end > NUM_P) ? NUM_P - 1'b1 : range_end - 1'b1;
                    end
                end
            end
            default:
            begin
                cmd.kind = bpa_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

[hw/rtl/bpa_fifo.sv]
module bpa_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bpa_pkg::cmd_t  push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output bpa_pkg::cmd_t  head
);

    bpa_pkg::cmd_t  entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    // advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/bpa_engine.sv]
`include "bitmap_page_allocator_macros.svh"

module bpa_engine #(
    parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [bpa_pkg::ADDR_W-1:0]     direct_map_offset,
    input  logic [bpa_pkg::USABLE_W-1:0]   usable_pages,
    input  logic                           cmd_valid,
    input  bpa_pkg::cmd_t                  cmd,
    output logic                           cmd_pop,
    output logic                           clearing,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bpa_pkg::ADDR_W-1:0]     m_tdata,
    output logic [bpa_pkg::STATUS_W-1:0]   m_tuser
);

    localparam int WORDS  = (NUM_PAGES + 63) / 64;
    localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(WORDS - 1);
    localparam logic [bpa_pkg::PAGE_W-1:0] NUM_P = bpa_pkg::PAGE_W'(NUM_PAGES);

    logic [63:0]                    mem [WORDS];
    logic [63:0]                    rd_data_reg;
    bpa_pkg::eng_state_t            state_reg, state_next;
    logic [WORD_W-1:0]              word_reg, word_next;
    bpa_pkg::cmd_t                  cmd_reg, cmd_next;
    logic                           out_valid_reg, out_valid_next;
    logic [bpa_pkg::ADDR_W-1:0]     out_addr_reg, out_addr_next;
    logic [bpa_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;

    logic                           mem_we;
    logic [WORD_W-1:0]              mem_wa;
    logic [63:0]                    mem_wd;
    logic                           res_load;
    logic [bpa_pkg::ADDR_W-1:0]     res_addr;
    logic [bpa_pkg::STATUS_W-1:0]   res_status;

    logic [bpa_pkg::PAGE_W-1:0]     usable_rnd;
    logic [bpa_pkg::PAGE_W-1:0]     lim;
    logic [WORD_W-1:0]              lim_last_w;
    logic [63:0]                    tail_mask;
    logic [63:0]                    free_bits;
    logic [63:0]                    low_onehot;
    logic [5:0]                     low_idx;
    logic [WORD_W-1:0]              lo_w, hi_w;
    logic [5:0]                     lo_bit, hi_bit;
    logic [63:0]                    range_mask;
    logic [bpa_pkg::ADDR_W-1:0]     found_page;
    logic                           can_take;

    // search limit: rounded to eight pages, capped at the map size
    assign usable_rnd = bpa_pkg::PAGE_W'({usable_pages[15:3], 3'b000});
    assign lim        = (usable_rnd > NUM_P) ? NUM_P : usable_rnd;
    assign lim_last_w = WORD_W'((lim - 1'b1) >> 6);
    assign tail_mask  = (word_reg == lim_last_w && lim[5:0] != 6'd0)
                        ? ((64'd1 << lim[5:0]) - 64'd1) : {64{1'b1}};

    // lowest free page in the word under test
    assign free_bits  = ~rd_data_reg & tail_mask;
    assign low_onehot = free_bits & (~free_bits + 64'd1);
    always_comb
    begin
        low_idx = '0;
        for (int b = 0; b < 64; b++)
        begin
            if (low_onehot[b])
            begin
                low_idx = low_idx | 6'(b);
            end
        end
    end
    assign found_page = (bpa_pkg::ADDR_W'(word_reg) << 6) | bpa_pkg::ADDR_W'(low_idx);

    // bits of the current word inside the command's page range
    assign lo_w       = WORD_W'(cmd_reg.lo >> 6);
    assign hi_w       = WORD_W'(cmd_reg.hi >> 6);
    assign lo_bit     = (word_reg == lo_w) ? cmd_reg.lo[5:0] : 6'd0;
    assign hi_bit     = (word_reg == hi_w) ? cmd_reg.hi[5:0] : 6'd63;
    assign range_mask = ({64{1'b1}} << lo_bit) & ({64{1'b1}} >> (6'd63 - hi_bit));

    assign can_take = cmd_valid && (!out_valid_reg || m_tready);
    assign clearing = (state_reg == bpa_pkg::ST_CLEAR);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpa_pkg::ST_CLEAR:
            begin
                if (word_reg == LAST_WORD)
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            bpa_pkg::ST_IDLE:
            begin
                if (can_take)
                begin
                    priority case (1'b1)
                        cmd.kind == bpa_pkg::CMD_ALLOC && lim != '0:
                            state_next = bpa_pkg::ST_SCAN_RD;
                        cmd.kind == bpa_pkg::CMD_FREE || cmd.kind == bpa_pkg::CMD_MARK:
                            state_next = bpa_pkg::ST_RMW_RD;
                        default:
                            state_next = bpa_pkg::ST_IDLE;
                    endcase
                end
            end
            bpa_pkg::ST_SCAN_RD:
            begin
                state_next = bpa_pkg::ST_SCAN_CHK;
            end
            bpa_pkg::ST_SCAN_CHK:
            begin
                if (free_bits != '0 || word_reg == lim_last_w)
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = bpa_pkg::ST_SCAN_RD;
                end
            end
            bpa_pkg::ST_RMW_RD:
            begin
                state_next = bpa_pkg::ST_RMW_WR;
            end
            bpa_pkg::ST_RMW_WR:
            begin
                state_next = (word_reg == hi_w) ? bpa_pkg::ST_IDLE : bpa_pkg::ST_RMW_RD;
            end
            default:
            begin
                state_next = bpa_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath controls per state
    always_comb
    begin
        cmd_pop    = 1'b0;
        cmd_next   = cmd_reg;
        word_next  = word_reg;
        mem_we     = 1'b0;
        mem_wa     = word_reg;
        mem_wd     = '0;
        res_load   = 1'b0;
        res_addr   = '0;
        res_status = bpa_pkg::STATUS_OK;
        unique case (state_reg)
            bpa_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wd    = (word_reg == '0) ? 64'd1 : 64'd0;
                word_next = word_reg + 1'b1;
            end
            bpa_pkg::ST_IDLE:
            begin
                if (can_take)
                begin
                    cmd_pop   = 1'b1;
                    cmd_next  = cmd;
                    word_next = (cmd.kind == bpa_pkg::CMD_ALLOC) ? '0 : WORD_W'(cmd.lo >> 6);
                    if (cmd.kind == bpa_pkg::CMD_NOP)
                    begin
                        res_load   = 1'b1;
                        res_status = cmd.status;
                    end
                    else if (cmd.kind == bpa_pkg::CMD_ALLOC && lim == '0)
                    begin
                        res_load   = 1'b1;
                        res_status = bpa_pkg::STATUS_NONE_FREE;
                    end
                end
            end
            bpa_pkg::ST_SCAN_RD:
            begin
                word_next = word_reg;
            end
            bpa_pkg::ST_SCAN_CHK:
            begin
                if (free_bits != '0)
                begin
                    mem_we   = 1'b1;
                    mem_wd   = rd_data_reg | low_onehot;
                    res_load = 1'b1;
                    res_addr = (found_page << PAGE_SHIFT) + direct_map_offset;
                end
                else if (word_reg == lim_last_w)
                begin
                    res_load   = 1'b1;
                    res_status = bpa_pkg::STATUS_NONE_FREE;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                end
            end
            bpa_pkg::ST_RMW_RD:
            begin
                word_next = word_reg;
            end
            bpa_pkg::ST_RMW_WR:
            begin
                mem_we = 1'b1;
                mem_wd = (cmd_reg.kind == bpa_pkg::CMD_FREE) ? (rd_data_reg & ~range_mask)
                                                             : (rd_data_reg | range_mask);
                if (word_reg == hi_w)
                begin
                    res_load   = 1'b1;
                    res_status = cmd_reg.status;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    // output register: load a result, drop it once taken
    always_comb
    begin
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        if (res_load)
        begin
            out_valid_next  = 1'b1;
            out_addr_next   = res_addr;
            out_status_next = res_status;
        end
        else if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpa_pkg::ST_CLEAR;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    // bitmap memory, one word written and one read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[word_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_status_reg;

    `BPA_ASSERT_IMP(a_busy_no_result, clk, rst_n,
        state_reg != bpa_pkg::ST_IDLE && state_reg != bpa_pkg::ST_CLEAR, !out_valid_reg,
        "result pending while a command is in progress")
    `BPA_ASSERT_IMP(a_no_pop_clear, clk, rst_n,
        state_reg == bpa_pkg::ST_CLEAR, !cmd_pop, "command taken during map clear")
    `BPA_ASSERT(a_scan_in_limit, clk, rst_n,
        state_reg != bpa_pkg::ST_SCAN_CHK || word_reg <= lim_last_w,
        "scan ran past the search limit")

endmodule

[hw/rtl/bitmap_page_allocator.sv]
// Bitmap first-fit page allocator.
// Input words arrive on s_tvalid/s_tready: s_tuser carries the action
// (allocate, free, mark range used), s_tdata the address and range fields.
// Each word yields one result word on m_tvalid/m_tready: m_tdata is the
// allocated virtual address, m_tuser the status.
// Registers are written on cfg_valid/cfg_ready: index 0 direct-map offset,
// index 1 usable page count; write them only while the block is idle.
// A front end classifies words into a two-entry command queue; a back end
// walks the bitmap memory one 64-page word at a time, reading each word
// and then checking or rewriting it. Allocate scans words from word 0 up
// to the first free page below the search limit; free rewrites one word; a
// range mark rewrites each word it touches; no-op cases answer from idle.
// After reset the map memory is cleared word by word, with page 0 left
// used; s_tready stays low meanwhile.
// A stalled result is held in the output register; the queue keeps taking
// words until it is full.
module bitmap_page_allocator #(
    parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] page_address, [78:64] range_first_page, [94:79] range_page_count
    input  logic [95:0]                     s_tdata,
    // [1:0] action
    input  logic [bpa_pkg::ACTION_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] alloc_address
    output logic [bpa_pkg::ADDR_W-1:0]      m_tdata,
    // [1:0] status
    output logic [bpa_pkg::STATUS_W-1:0]    m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpa_pkg::ADDR_W-1:0]      cfg_data
);

    logic [bpa_pkg::ADDR_W-1:0]     offset_reg;
    logic [bpa_pkg::USABLE_W-1:0]   usable_reg;
    logic                           clearing;
    logic                           fifo_full;
    logic                           fifo_not_empty;
    logic                           push;
    logic                           pop;
    bpa_pkg::cmd_t                  push_cmd;
    bpa_pkg::cmd_t                  head_cmd;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            usable_reg <= bpa_pkg::USABLE_W'(32768);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bpa_pkg::REG_DIRECT_MAP_OFFSET: offset_reg <= cfg_data;
                bpa_pkg::REG_USABLE_PAGES:      usable_reg <= cfg_data[15:0];
                default:                        offset_reg <= offset_reg;
            endcase
        end
    end

    bpa_front #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .direct_map_offset (offset_reg),
        .clearing          (clearing),
        .fifo_full         (fifo_full),
        .push              (push),
        .cmd               (push_cmd)
    );

    bpa_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (fifo_full),
        .not_empty (fifo_not_empty),
        .head      (head_cmd)
    );

    bpa_engine #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .direct_map_offset (offset_reg),
        .usable_pages      (usable_reg),
        .cmd_valid         (fifo_not_empty),
        .cmd               (head_cmd),
        .cmd_pop           (pop),
        .clearing          (clearing),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser)
    );

endmodule
